[sv/uvpd_pkg.sv]
// Package for the validated URL percent decoder: byte codes, escape phase type
// and the hex and safe-set helper functions.
// No dependencies.
package uvpd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[8'd48:8'd57], [8'd97:8'd102], [8'd65:8'd70]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c inside {[8'd48:8'd57]}) begin
			v = c - 8'd48;
		end else if (c inside {[8'd97:8'd102]}) begin
			v = c - 8'd87;
		end else if (c inside {[8'd65:8'd70]}) begin
			v = c - 8'd55;
		end
		return v[3:0];
	endfunction

	function automatic logic is_safe(input logic [7:0] v);
		return (v inside {[8'd48:8'd57], [8'd97:8'd122], [8'd65:8'd90],
			8'h21, 8'h24, 8'h5F, 8'h40, [8'h26:8'h2F],
			8'h3A, 8'h3B, 8'h3D, 8'h3F});
	endfunction

endpackage

[sv/url_validated_percent_decoder.sv]
// Top level of the validated URL percent decoder: input register, decode
// logic and a three-entry result shift buffer.
// Depends on uvpd_pkg.
//
// channel  dir  tdata           tlast      tuser
// s_*      in   in_byte [7:0]   text_end   -
// m_*      out  out_byte [7:0]  run_last   text_done
//
// One input byte is taken per cycle while each byte yields at most one result and the output is ready.
// A byte that yields several results stalls the input until all but its last result have drained.
// The result buffer drains one byte per cycle while m_tready is high; it sets the rate for expanding bytes.
// Each byte is held in the input register, then its results in the result buffer.
// arst_n clears the escape state and all valid flags.
module url_validated_percent_decoder
	import uvpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // text_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // run_last
	output logic       m_tuser    // [0] text_done
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	phase_t     phase_q;
	logic [7:0] held_q;

	logic [7:0] buf_q [3];
	logic [1:0] rem_q;
	logic       end_q;

	logic       buf_free;
	logic       take;
	logic       drain;

	logic [7:0] r [3];
	logic [1:0] dec_n;
	phase_t     nph;
	logic [7:0] nheld;
	logic [7:0] pl_byte;
	logic       pl_esc;
	logic [7:0] dv;

	assign drain    = m_tvalid && m_tready;
	assign buf_free = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);
	assign take     = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || take;

	assign m_tvalid = (rem_q != 2'd0);
	assign m_tdata  = buf_q[0];
	assign m_tlast  = (rem_q == 2'd1);
	assign m_tuser  = m_tlast && end_q;

	always_comb begin
		pl_byte = (byte_s1 == CH_PLUS) ? CH_SPACE : byte_s1;
		pl_esc  = (byte_s1 == CH_PERCENT);
		dv      = {hex_val(held_q), hex_val(byte_s1)};
		r[0]    = 8'd0;
		r[1]    = 8'd0;
		r[2]    = 8'd0;
		dec_n   = 2'd0;
		nph     = PH_IDLE;
		nheld   = held_q;
		case (phase_q)
			PH_PCT: begin
				if (is_hex(byte_s1)) begin
					nph   = PH_DIGIT;
					nheld = byte_s1;
				end else begin
					r[0] = CH_PERCENT;
					if (pl_esc) begin
						nph   = PH_PCT;
						dec_n = 2'd1;
					end else begin
						r[1]  = pl_byte;
						dec_n = 2'd2;
					end
				end
			end
			PH_DIGIT: begin
				nheld = 8'd0;
				if (is_hex(byte_s1)) begin
					if (!is_safe(dv)) begin
						r[0]  = dv;
						dec_n = 2'd1;
					end else begin
						r[0]  = CH_PERCENT;
						r[1]  = held_q;
						r[2]  = byte_s1;
						dec_n = 2'd3;
					end
				end else begin
					r[0] = CH_PERCENT;
					r[1] = held_q;
					if (pl_esc) begin
						nph   = PH_PCT;
						dec_n = 2'd2;
					end else begin
						r[2]  = pl_byte;
						dec_n = 2'd3;
					end
				end
			end
			default: begin
				if (pl_esc) begin
					nph = PH_PCT;
				end else begin
					r[0]  = pl_byte;
					dec_n = 2'd1;
				end
			end
		endcase
		if (end_s1) begin
			if (nph == PH_DIGIT) begin
				r[0]  = CH_PERCENT;
				r[1]  = nheld;
				dec_n = 2'd2;
			end else if (nph == PH_PCT) begin
				case (dec_n)
					2'd0: r[0] = CH_PERCENT;
					2'd1: r[1] = CH_PERCENT;
					default: r[2] = CH_PERCENT;
				endcase
				dec_n = dec_n + 2'd1;
			end
			nph   = PH_IDLE;
			nheld = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
			rem_q   <= 2'd0;
			end_q   <= 1'b0;
		end else if (take) begin
			phase_q <= nph;
			held_q  <= nheld;
			rem_q   <= dec_n;
			end_q   <= end_s1;
		end else if (drain) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q[0] <= r[0];
			buf_q[1] <= r[1];
			buf_q[2] <= r[2];
		end else if (drain) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("text_done without run_last");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take && (dec_n != 2'd0) |=> m_tvalid)
		else $error("decoded request not presented");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_s1 |=> (phase_q == PH_IDLE) && (held_q == 8'd0))
		else $error("escape state not cleared at end of text");

	a_end_yields: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_s1 |-> dec_n != 2'd0)
		else $error("final byte produced no result");

endmodule
